// ===== sv/radio_module_config_handshake_unit_assert.svh =====
// Assertion macros shared by the radio module setup handshake RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef RADIO_MODULE_CONFIG_HANDSHAKE_UNIT_ASSERT_SVH
`define RADIO_MODULE_CONFIG_HANDSHAKE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCFG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rcfg_pkg.sv =====
// Package for the radio module setup handshake: codes, banner ROM, helpers.
// No dependencies; used by rcfg_tracker and the top level.
`default_nettype none

package rcfg_pkg;

  localparam int BANNER_LENGTH = 27;
  localparam int IDX_W         = $clog2(BANNER_LENGTH + 1);

  localparam logic [7:0]  FRAME_MARK    = 8'hC6;
  localparam logic [7:0]  CHANNEL_TAG   = 8'hC0;
  localparam logic [7:0]  DIGIT_ZERO    = 8'h30;
  localparam logic [15:0] TIMEOUT_RESET = 16'hFFFE;
  localparam logic [3:0]  DEFAULT_CHAN  = 4'd7;

  // Positions in the banner that depend on the exchange settings
  localparam logic [IDX_W-1:0] POS_BAUD_HI = IDX_W'(15);
  localparam logic [IDX_W-1:0] POS_BAUD_LO = IDX_W'(16);
  localparam logic [IDX_W-1:0] POS_PARITY  = IDX_W'(21);
  localparam logic [IDX_W-1:0] POS_CHANNEL = IDX_W'(26);

  typedef enum logic [1:0] {
    OP_CONFIGURE = 2'd0,
    OP_PRESENCE  = 2'd1,
    OP_RX_BYTE   = 2'd2,
    OP_IDLE_POLL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_BAD_MODE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2,
    PAR_RSVD = 2'd3
  } parity_t;

  localparam logic [1:0] REG_CODE_NONE = 2'd0;
  localparam logic [1:0] REG_CODE_EVEN = 2'd1;
  localparam logic [1:0] REG_CODE_ODD  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam logic [7:0] BANNER_ROM [BANNER_LENGTH] = '{
    8'h75, 8'h50, 8'h73, 8'h39, 8'h36, 8'h5A, 8'h30, 8'h36, 8'h50, 8'h5F,
    8'h56, 8'h32, 8'h2E, 8'h31, 8'h20, 8'h39, 8'h36, 8'h30, 8'h30, 8'h20,
    8'h38, 8'h4E, 8'h31, 8'h20, 8'h43, 8'h48, 8'h37
  };

  // Event handed from the top level to the exchange tracker
  typedef struct packed {
    logic       fire;
    op_t        op;
    logic [1:0] baud;
    parity_t    parity;
    logic [3:0] chan;
    logic [7:0] rx;
  } trk_evt_t;

  function automatic logic [7:0] baud_code(input logic [1:0] baud);
    logic [7:0] code;
    case (baud)
      2'd0:    code = 8'h96;
      2'd1:    code = 8'h48;
      2'd2:    code = 8'h24;
      default: code = 8'h12;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] expected_char(input logic [IDX_W-1:0] idx,
                                               input logic [1:0] baud,
                                               input parity_t parity,
                                               input logic [3:0] chan);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] letter;
    logic [7:0] ch;
    case (baud)
      2'd0:    begin hi = 8'h39; lo = 8'h36; end
      2'd1:    begin hi = 8'h34; lo = 8'h38; end
      2'd2:    begin hi = 8'h32; lo = 8'h34; end
      default: begin hi = 8'h31; lo = 8'h32; end
    endcase
    case (parity)
      PAR_EVEN: letter = 8'h45;
      PAR_ODD:  letter = 8'h4F;
      default:  letter = 8'h4E;
    endcase
    if (idx >= IDX_W'(BANNER_LENGTH))  ch = 8'h00;
    else if (idx == POS_BAUD_HI)       ch = hi;
    else if (idx == POS_BAUD_LO)       ch = lo;
    else if (idx == POS_PARITY)        ch = letter;
    else if (idx == POS_CHANNEL)       ch = DIGIT_ZERO + {4'd0, chan};
    else                               ch = BANNER_ROM[idx];
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rcfg_tracker.sv =====
// Exchange tracker: banner match index, miss counter and expected settings.
// Depends on rcfg_pkg and the assertion macro header.
`default_nettype none

module rcfg_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rcfg_pkg::trk_evt_t evt,
  input  wire logic [15:0]       timeout_limit,
  output rcfg_pkg::status_t      status
);
  import rcfg_pkg::*;

  `include "radio_module_config_handshake_unit_assert.svh"

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      miss_r, miss_nxt;
  logic [1:0]       baud_r, baud_nxt;
  parity_t          parity_r, parity_nxt;
  logic [3:0]       chan_r, chan_nxt;
  logic             hit;

  assign hit = (evt.op == OP_RX_BYTE) && (idx_r < IDX_W'(BANNER_LENGTH)) &&
               (evt.rx == expected_char(idx_r, baud_r, parity_r, chan_r));

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    miss_nxt   = miss_r;
    baud_nxt   = baud_r;
    parity_nxt = parity_r;
    chan_nxt   = chan_r;
    status     = ST_BUSY;
    if (evt.fire) begin
      case (evt.op)
        OP_CONFIGURE: begin
          active_nxt = 1'b1;
          idx_nxt    = '0;
          miss_nxt   = '0;
          baud_nxt   = evt.baud;
          parity_nxt = evt.parity;
          chan_nxt   = evt.chan;
        end
        OP_PRESENCE: begin
          active_nxt = 1'b1;
          idx_nxt    = '0;
          miss_nxt   = '0;
          baud_nxt   = 2'd0;
          parity_nxt = PAR_NONE;
          chan_nxt   = DEFAULT_CHAN;
        end
        default: begin
          if (active_r) begin
            if (hit) begin
              idx_nxt = idx_r + IDX_W'(1);
            end else begin
              if (evt.op == OP_RX_BYTE) idx_nxt = '0;
              if (miss_r != 16'hFFFF) miss_nxt = miss_r + 16'd1;
            end
            if (idx_nxt >= IDX_W'(BANNER_LENGTH)) begin
              active_nxt = 1'b0;
              status     = ST_MATCHED;
            end else if (miss_nxt >= timeout_limit) begin
              active_nxt = 1'b0;
              status     = ST_TIMEOUT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      miss_r   <= '0;
      baud_r   <= 2'd0;
      parity_r <= PAR_NONE;
      chan_r   <= DEFAULT_CHAN;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      miss_r   <= miss_nxt;
      baud_r   <= baud_nxt;
      parity_r <= parity_nxt;
      chan_r   <= chan_nxt;
    end
  end

  `RCFG_ASSERT_NXT(a_end_on_result, evt.fire && status != ST_BUSY, !active_r,
                   "exchange still active after match or timeout")
  `RCFG_ASSERT_IMP(a_idx_in_banner, active_r, idx_r < IDX_W'(BANNER_LENGTH),
                   "match index past banner while active")
  `RCFG_ASSERT_NXT(a_start_clean,
                   evt.fire && (evt.op == OP_CONFIGURE || evt.op == OP_PRESENCE),
                   active_r && idx_r == '0 && miss_r == '0,
                   "new exchange did not start from a clean state")

endmodule

`default_nettype wire

// ===== sv/radio_module_config_handshake_unit.sv =====
// Top level of the radio module setup handshake: ports, registers, frame sender.
// Depends on rcfg_pkg, rcfg_tracker and the assertion macro header.
//
//   channel | direction | transfer carries
//   in_*    | input     | operation, baud_select, mode_byte, channel, rx_byte
//   out_*   | output    | tx_byte, tx_valid, last, status (one result per transfer)
//   cfg_*   | input     | register index and write data
//
// A received byte, an idle poll, a presence check or a rejected configure gives one
// result in the cycle after its transfer; one item can be taken every cycle while
// the output is not stalled. A valid configure gives seven frame bytes, sent by the
// frame sequencer, and the input is held off until the last byte is loaded.
// A stalled result holds in the output register; input waits only when it is full.
// Synchronous active-low reset clears control state and reloads register defaults.
`default_nettype none

module radio_module_config_handshake_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [1:0]  in_baud_select,
  input  wire logic [7:0]  in_mode_byte,
  input  wire logic [3:0]  in_channel,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_valid,
  output logic             out_last,
  output logic [1:0]       out_status,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rcfg_pkg::*;

  `include "radio_module_config_handshake_unit_assert.svh"

  // Configuration registers
  logic [7:0]  code_none_r;
  logic [7:0]  code_even_r;
  logic [7:0]  code_odd_r;
  logic [15:0] timeout_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_tx_byte_r, out_tx_byte_nxt;
  logic        out_tx_valid_r, out_tx_valid_nxt;
  logic        out_last_r, out_last_nxt;
  status_t     out_status_r, out_status_nxt;

  // Frame sequencer: position of the next frame byte, zero when none is pending
  logic [2:0]  frame_pos_r, frame_pos_nxt;
  logic [7:0]  frame_baud_r, frame_baud_nxt;
  logic [7:0]  frame_mode_r, frame_mode_nxt;
  logic [7:0]  frame_chan_r, frame_chan_nxt;
  logic [7:0]  frame_sum_r, frame_sum_nxt;

  op_t         op;
  logic        in_fire;
  logic        pop;
  logic        mode_ok;
  parity_t     parity_sel;
  trk_evt_t    evt;
  status_t     trk_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_none_r <= 8'd0;
      code_even_r <= 8'd1;
      code_odd_r  <= 8'd2;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CODE_NONE: code_none_r <= cfg_data[7:0];
        REG_CODE_EVEN: code_even_r <= cfg_data[7:0];
        REG_CODE_ODD:  code_odd_r  <= cfg_data[7:0];
        REG_TIMEOUT:   timeout_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Decode the mode byte; the first matching register in order wins
  always_comb begin
    mode_ok    = 1'b1;
    parity_sel = PAR_NONE;
    if (in_mode_byte == code_none_r)      parity_sel = PAR_NONE;
    else if (in_mode_byte == code_even_r) parity_sel = PAR_EVEN;
    else if (in_mode_byte == code_odd_r)  parity_sel = PAR_ODD;
    else                                  mode_ok    = 1'b0;
  end

  assign op       = op_t'(in_operation);
  assign pop      = out_valid_r && out_ready;
  assign in_ready = (frame_pos_r == 3'd0) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Drop a rejected configure before it reaches the tracker
  always_comb begin
    evt.fire   = in_fire && ((op != OP_CONFIGURE) || mode_ok);
    evt.op     = op;
    evt.baud   = in_baud_select;
    evt.parity = parity_sel;
    evt.chan   = in_channel;
    evt.rx     = in_rx_byte;
  end

  rcfg_tracker u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt           (evt),
    .timeout_limit (timeout_r),
    .status        (trk_status)
  );

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_tx_byte_nxt  = out_tx_byte_r;
    out_tx_valid_nxt = out_tx_valid_r;
    out_last_nxt     = out_last_r;
    out_status_nxt   = out_status_r;
    frame_pos_nxt    = frame_pos_r;
    frame_baud_nxt   = frame_baud_r;
    frame_mode_nxt   = frame_mode_r;
    frame_chan_nxt   = frame_chan_r;
    frame_sum_nxt    = frame_sum_r;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (op == OP_CONFIGURE && mode_ok) begin
        // Send the first mark now, latch the rest of the frame
        out_tx_byte_nxt  = FRAME_MARK;
        out_tx_valid_nxt = 1'b1;
        out_last_nxt     = 1'b0;
        out_status_nxt   = ST_BUSY;
        frame_pos_nxt    = 3'd1;
        frame_baud_nxt   = baud_code(in_baud_select);
        frame_mode_nxt   = in_mode_byte;
        frame_chan_nxt   = {4'd0, in_channel} | CHANNEL_TAG;
        frame_sum_nxt    = baud_code(in_baud_select) + in_mode_byte +
                           ({4'd0, in_channel} | CHANNEL_TAG);
      end else begin
        out_tx_byte_nxt  = 8'd0;
        out_tx_valid_nxt = 1'b0;
        out_last_nxt     = 1'b1;
        out_status_nxt   = (op == OP_CONFIGURE) ? ST_BAD_MODE : trk_status;
      end
    end else if (pop && frame_pos_r != 3'd0) begin
      // Advance through the frame one byte per transfer
      out_valid_nxt    = 1'b1;
      out_tx_valid_nxt = 1'b1;
      out_last_nxt     = 1'b0;
      out_status_nxt   = ST_BUSY;
      frame_pos_nxt    = frame_pos_r + 3'd1;
      case (frame_pos_r)
        3'd3:    out_tx_byte_nxt = frame_baud_r;
        3'd4:    out_tx_byte_nxt = frame_mode_r;
        3'd5:    out_tx_byte_nxt = frame_chan_r;
        3'd6: begin
          out_tx_byte_nxt = frame_sum_r;
          out_last_nxt    = 1'b1;
          frame_pos_nxt   = 3'd0;
        end
        default: out_tx_byte_nxt = FRAME_MARK;
      endcase
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frame_pos_r <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      frame_pos_r <= frame_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tx_byte_r  <= out_tx_byte_nxt;
    out_tx_valid_r <= out_tx_valid_nxt;
    out_last_r     <= out_last_nxt;
    out_status_r   <= out_status_nxt;
    frame_baud_r   <= frame_baud_nxt;
    frame_mode_r   <= frame_mode_nxt;
    frame_chan_r   <= frame_chan_nxt;
    frame_sum_r    <= frame_sum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_tx_byte  = out_tx_byte_r;
  assign out_tx_valid = out_tx_valid_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

  `RCFG_ASSERT_IMP(a_frame_continues, out_valid_r && out_tx_valid_r && !out_last_r,
                   frame_pos_r != 3'd0, "frame byte without a follow-on byte pending")
  `RCFG_ASSERT_IMP(a_pending_has_output, frame_pos_r != 3'd0, out_valid_r,
                   "frame pending with empty output register")
  `RCFG_ASSERT_NXT(a_frame_starts,
                   in_fire && op == OP_CONFIGURE && mode_ok,
                   out_valid_r && out_tx_valid_r && out_tx_byte_r == FRAME_MARK &&
                   frame_pos_r == 3'd1,
                   "accepted configure did not start a frame")

endmodule

`default_nettype wire
